/* rtl/bes_pkg.sv */
// Shared types, constants and controller/datapath interface structs of the echo suppressor.
`default_nettype none
package bes_pkg;
	localparam int ENTRIES_DEF   = 64;
	localparam int MAX_FRAME_DEF = 2048;
	localparam int EXPIRY_RESET  = 2;
	localparam int SRC_MAC_FIRST = 6;
	localparam int SRC_MAC_END   = 12;
	localparam int CFG_AW        = 4;
	localparam int CFG_DW        = 64;
	localparam logic REG_OWN_MAC = 1'b0;
	localparam logic REG_EXPIRY  = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_PEND = 2'd0,
		VERDICT_FWD  = 2'd1,
		VERDICT_DROP = 2'd2
	} verdict_t;

	typedef struct packed {
		logic accept;
		logic ld_i0;
		logic inc_i;
		logic ld_j0;
		logic inc_j;
		logic own_tbl;
		logic free_match;
		logic write_slot;
		logic copy_wr;
		logic fin;
		logic fin_drop;
		logic fin_rec;
	} bes_cmd_t;

	typedef struct packed {
		logic ovl;
		logic len_hit;
		logic byte_eq;
		logic j_last;
		logic i_last;
		logic slot_ok;
		logic out_free;
	} bes_status_t;
endpackage
`default_nettype wire

/* rtl/bes_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/bes_ctrl.sv */
// Controller state machine sequencing byte intake, echo search, slot search and copy.
`default_nettype none
module bes_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 last_of_frame,
	output logic                      in_stall,
	input  wire bes_pkg::bes_status_t st,
	output bes_pkg::bes_cmd_t         cmd
);
	import bes_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_START   = 10'b0000000010,
		S_MLEN_RD = 10'b0000000100,
		S_MLEN_CK = 10'b0000001000,
		S_MCMP_RD = 10'b0000010000,
		S_MCMP_CK = 10'b0000100000,
		S_SLOT_RD = 10'b0001000000,
		S_SLOT_CK = 10'b0010000000,
		S_COPY_RD = 10'b0100000000,
		S_COPY_WR = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = !((state_q == S_IDLE) && st.out_free);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid && !in_stall;
				if (cmd.accept && last_of_frame) begin
					state_d = S_START;
				end
			end
			S_START: begin
				if (st.ovl) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.ld_i0 = 1'b1;
					state_d   = S_MLEN_RD;
				end
			end
			S_MLEN_RD: state_d = S_MLEN_CK;
			S_MLEN_CK: begin
				if (st.len_hit) begin
					cmd.ld_j0 = 1'b1;
					state_d   = S_MCMP_RD;
				end else if (st.i_last) begin
					cmd.ld_i0 = 1'b1;
					state_d   = S_SLOT_RD;
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = S_MLEN_RD;
				end
			end
			S_MCMP_RD: state_d = S_MCMP_CK;
			S_MCMP_CK: begin
				if (!st.byte_eq) begin
					if (st.i_last) begin
						cmd.ld_i0 = 1'b1;
						state_d   = S_SLOT_RD;
					end else begin
						cmd.inc_i = 1'b1;
						state_d   = S_MLEN_RD;
					end
				end else if (st.j_last) begin
					cmd.free_match = 1'b1;
					cmd.fin        = 1'b1;
					cmd.fin_drop   = 1'b1;
					state_d        = S_IDLE;
				end else begin
					cmd.inc_j = 1'b1;
					state_d   = S_MCMP_RD;
				end
			end
			S_SLOT_RD: begin
				cmd.own_tbl = 1'b1;
				state_d     = S_SLOT_CK;
			end
			S_SLOT_CK: begin
				cmd.own_tbl = 1'b1;
				if (st.slot_ok) begin
					cmd.write_slot = 1'b1;
					cmd.ld_j0      = 1'b1;
					state_d        = S_COPY_RD;
				end else if (st.i_last) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.inc_i = 1'b1;
					state_d   = S_SLOT_RD;
				end
			end
			S_COPY_RD: state_d = S_COPY_WR;
			S_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				if (st.j_last) begin
					cmd.fin     = 1'b1;
					cmd.fin_rec = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.inc_j = 1'b1;
					state_d   = S_COPY_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

/* rtl/bes_datapath.sv */
// Datapath: frame buffers, record tables, counters and the output register.
`default_nettype none
module bes_datapath #(
	parameter int ENTRIES   = bes_pkg::ENTRIES_DEF,
	parameter int MAX_FRAME = bes_pkg::MAX_FRAME_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bes_pkg::bes_cmd_t cmd,
	output bes_pkg::bes_status_t   st,
	input  wire logic [47:0]       own_mac,
	input  wire logic [7:0]        expiry_seconds,
	input  wire logic              arrival_port,
	input  wire logic [7:0]        data_byte,
	input  wire logic              first_of_frame,
	input  wire logic              last_of_frame,
	input  wire logic [31:0]       time_seconds,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             out_byte,
	output logic                   destination_port,
	output logic                   frame_end,
	output logic [1:0]             verdict,
	output logic                   recorded
);
	import bes_pkg::*;

	localparam int SW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW  = $clog2(MAX_FRAME);
	localparam int LW  = $clog2(MAX_FRAME + 1);
	localparam int RAW = 1 + SW + OW;

	logic [LW-1:0]  off_q, off, len_q;
	logic           ovl_q, ovl_last_q, port_q;
	logic [31:0]    now_q;
	logic [SW-1:0]  i_q;
	logic [OW-1:0]  j_q;
	logic [1:0][ENTRIES-1:0] valid_q;
	logic           out_valid_q, out_end_q, out_dest_q, out_rec_q;
	logic [7:0]     out_byte_q;
	verdict_t       out_verdict_q;
	logic           in_range, mac_sel, other, tbl;
	logic [2:0]     mac_idx;
	logic [7:0]     ob, fin_rd, fout_rd, rec_rd;
	logic [LW-1:0]  len_rd;
	logic [31:0]    stamp_rd;

	assign off      = first_of_frame ? '0 : off_q;
	assign in_range = off < LW'(MAX_FRAME);
	assign mac_sel  = !arrival_port && (off >= LW'(SRC_MAC_FIRST)) && (off < LW'(SRC_MAC_END));
	assign mac_idx  = 3'(4'(SRC_MAC_END - 1) - off[3:0]);
	assign ob       = mac_sel ? own_mac[{mac_idx, 3'b000} +: 8] : data_byte;
	assign other    = ~port_q;
	assign tbl      = cmd.own_tbl ? port_q : other;

	bes_ram #(.WIDTH(8), .DEPTH(1 << OW)) u_fin (
		.clk(clk), .we(cmd.accept && in_range), .waddr(off[OW-1:0]), .wdata(data_byte),
		.raddr(j_q), .rdata_q(fin_rd));
	bes_ram #(.WIDTH(8), .DEPTH(1 << OW)) u_fout (
		.clk(clk), .we(cmd.accept && in_range), .waddr(off[OW-1:0]), .wdata(ob),
		.raddr(j_q), .rdata_q(fout_rd));
	bes_ram #(.WIDTH(LW), .DEPTH(2 << SW)) u_len (
		.clk(clk), .we(cmd.write_slot), .waddr({port_q, i_q}), .wdata(len_q),
		.raddr({tbl, i_q}), .rdata_q(len_rd));
	bes_ram #(.WIDTH(32), .DEPTH(2 << SW)) u_stamp (
		.clk(clk), .we(cmd.write_slot), .waddr({port_q, i_q}), .wdata(now_q),
		.raddr({tbl, i_q}), .rdata_q(stamp_rd));
	bes_ram #(.WIDTH(8), .DEPTH(1 << RAW)) u_rec (
		.clk(clk), .we(cmd.copy_wr), .waddr({port_q, i_q, j_q}), .wdata(fout_rd),
		.raddr({other, i_q, j_q}), .rdata_q(rec_rd));

	assign st.ovl      = ovl_last_q;
	assign st.len_hit  = valid_q[other][i_q] && (len_rd == len_q);
	assign st.byte_eq  = fin_rd == rec_rd;
	assign st.j_last   = (LW'(j_q) + LW'(1)) == len_q;
	assign st.i_last   = i_q == SW'(ENTRIES - 1);
	assign st.slot_ok  = !valid_q[port_q][i_q] || ((now_q - stamp_rd) > {24'd0, expiry_seconds});
	assign st.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			ovl_q       <= 1'b0;
			ovl_last_q  <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (last_of_frame) begin
					off_q      <= '0;
					ovl_q      <= 1'b0;
					ovl_last_q <= (ovl_q && !first_of_frame) || !in_range;
				end else begin
					off_q <= in_range ? off + LW'(1) : off;
					ovl_q <= (ovl_q && !first_of_frame) || !in_range;
				end
			end
			if (cmd.ld_i0) begin
				i_q <= '0;
			end else if (cmd.inc_i) begin
				i_q <= i_q + SW'(1);
			end
			if (cmd.ld_j0) begin
				j_q <= '0;
			end else if (cmd.inc_j) begin
				j_q <= j_q + OW'(1);
			end
			if (cmd.write_slot) begin
				valid_q[port_q][i_q] <= 1'b1;
			end
			if (cmd.free_match) begin
				valid_q[other][i_q] <= 1'b0;
			end
			if ((cmd.accept && !last_of_frame) || cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_byte_q    <= ob;
			out_dest_q    <= ~arrival_port;
			out_end_q     <= last_of_frame;
			out_verdict_q <= VERDICT_PEND;
			out_rec_q     <= 1'b0;
			if (last_of_frame) begin
				port_q <= arrival_port;
				now_q  <= time_seconds;
				len_q  <= in_range ? off + LW'(1) : off;
			end
		end
		if (cmd.fin) begin
			out_verdict_q <= cmd.fin_drop ? VERDICT_DROP : VERDICT_FWD;
			out_rec_q     <= cmd.fin_rec;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_byte         = out_byte_q;
	assign destination_port = out_dest_q;
	assign frame_end        = out_end_q;
	assign verdict          = out_verdict_q;
	assign recorded         = out_rec_q;
endmodule
`default_nettype wire

/* rtl/bridge_echo_suppressor.sv */
// Top level of the two-port frame relay with echo suppression.
// A byte that does not end its frame is presented in the cycle after it is taken.
// One such byte is taken per cycle while the output is not stalled, set by the single output register.
// A last byte holds the input through the length checks, the byte compares on a length
// hit, the slot search and the copy of each byte, all through single-port reads.
// Reset clears the table valid flags at once; no clearing pass is needed.
`default_nettype none
module bridge_echo_suppressor #(
	parameter int ENTRIES   = bes_pkg::ENTRIES_DEF,
	parameter int MAX_FRAME = bes_pkg::MAX_FRAME_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bes_pkg::CFG_AW-1:0] paddr,
	input  wire logic [bes_pkg::CFG_DW-1:0] pwdata,
	output logic      [bes_pkg::CFG_DW-1:0] prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       arrival_port,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       first_of_frame,
	input  wire logic                       last_of_frame,
	input  wire logic [31:0]                time_seconds,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [7:0]                      out_byte,
	output logic                            destination_port,
	output logic                            frame_end,
	output logic [1:0]                      verdict,
	output logic                            recorded
);
	import bes_pkg::*;

	logic [47:0] own_mac_q;
	logic [7:0]  expiry_q;
	bes_cmd_t    cmd;
	bes_status_t st;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			expiry_q  <= 8'(EXPIRY_RESET);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3])
				REG_OWN_MAC: own_mac_q <= pwdata[47:0];
				REG_EXPIRY:  expiry_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_OWN_MAC: prdata = {16'd0, own_mac_q};
			REG_EXPIRY:  prdata = {56'd0, expiry_q};
			default:     prdata = '0;
		endcase
	end

	bes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_of_frame(last_of_frame),
		.in_stall(in_stall), .st(st), .cmd(cmd));

	bes_datapath #(.ENTRIES(ENTRIES), .MAX_FRAME(MAX_FRAME)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.own_mac(own_mac_q), .expiry_seconds(expiry_q),
		.arrival_port(arrival_port), .data_byte(data_byte),
		.first_of_frame(first_of_frame), .last_of_frame(last_of_frame),
		.time_seconds(time_seconds), .out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .destination_port(destination_port), .frame_end(frame_end),
		.verdict(verdict), .recorded(recorded));
endmodule
`default_nettype wire

/* rtl/bes_checker.sv */
// Port-level assertions for the echo suppressor and their bind to the top level.
`default_nettype none
module bes_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       frame_end,
	input wire logic [1:0] verdict,
	input wire logic       recorded
);
	import bes_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Stalled request was withdrawn.");
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> verdict == VERDICT_PEND && !recorded)
		else $error("Verdict given before the end of the frame.");
	a_decided: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> verdict == VERDICT_FWD || verdict == VERDICT_DROP)
		else $error("Frame ended without a verdict.");
	a_rec_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && recorded |-> verdict == VERDICT_FWD)
		else $error("Dropped frame was recorded.");
endmodule

bind bridge_echo_suppressor bes_checker u_bes_checker (.*);
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the echo suppressor: random frames, echoes, table ageing and stalls.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import bes_pkg::*;

	localparam int NENT = 64;
	localparam int MAXF = 2048;

	typedef struct packed {
		logic        port;
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] secs;
	} req_t;

	typedef struct packed {
		logic [7:0] obyte;
		logic       dport;
		logic       fend;
		verdict_t   verd;
		logic       rec;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_stall;
	logic arrival_port = 1'b0, first_of_frame = 1'b0, last_of_frame = 1'b0;
	logic [7:0] data_byte = '0;
	logic [31:0] time_seconds = '0;
	logic out_valid, out_stall = 1'b0;
	logic [7:0] out_byte;
	logic destination_port, frame_end, recorded;
	logic [1:0] verdict;

	bridge_echo_suppressor u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	logic [47:0] mac_q = '0;
	logic [7:0]  expiry_q = 8'd2;
	int unsigned tbl_len [2][NENT];
	logic [31:0] tbl_stamp [2][NENT];
	logic [7:0]  tbl_bytes [2][NENT][];
	int unsigned held_len;
	bit          overlong;
	logic [7:0]  buf_in [MAXF];
	logic [7:0]  buf_out [MAXF];

	req_t pending_reqs[$];
	res_t expected_res[$];
	int   errors = 0, mismatches = 0, n_results = 0, n_drops = 0, n_recs = 0;
	bit   quiet = 1'b0;

	function automatic res_t relay_byte(req_t r);
		res_t o;
		int unsigned off;
		int m, s;
		bit eq;
		o.obyte = r.data;
		o.dport = ~r.port;
		o.fend = r.last;
		o.verd = VERDICT_PEND;
		o.rec = 1'b0;
		if (r.first) begin
			held_len = 0;
			overlong = 0;
		end
		off = held_len;
		if (!r.port && off >= SRC_MAC_FIRST && off < SRC_MAC_END)
			o.obyte = mac_q[8*(11-off) +: 8];
		if (off < MAXF) begin
			buf_in[off] = r.data;
			buf_out[off] = o.obyte;
			held_len = off + 1;
		end else
			overlong = 1;
		if (r.last) begin
			o.verd = VERDICT_FWD;
			if (!overlong) begin
				m = -1;
				for (int i = 0; i < NENT && m < 0; i++)
					if (tbl_len[!r.port][i] == held_len) begin
						eq = 1;
						for (int k = 0; k < held_len; k++)
							if (tbl_bytes[!r.port][i][k] !== buf_in[k])
								eq = 0;
						if (eq)
							m = i;
					end
				if (m >= 0) begin
					tbl_len[!r.port][m] = 0;
					o.verd = VERDICT_DROP;
				end else begin
					s = -1;
					for (int i = 0; i < NENT && s < 0; i++)
						if (tbl_len[r.port][i] == 0 ||
						    (r.secs - tbl_stamp[r.port][i]) > {24'd0, expiry_q})
							s = i;
					if (s >= 0) begin
						tbl_bytes[r.port][s] = new[held_len];
						for (int k = 0; k < held_len; k++)
							tbl_bytes[r.port][s][k] = buf_out[k];
						tbl_len[r.port][s] = held_len;
						tbl_stamp[r.port][s] = r.secs;
						o.rec = 1'b1;
					end
				end
			end
			held_len = 0;
			overlong = 0;
		end
		return o;
	endfunction

	// Driver.
	int gap = 0;
	bit hold = 1'b0;
	always @(posedge clk) begin
		req_t r;
		if (in_valid && !in_stall) begin
			expected_res.push_back(relay_byte({arrival_port, data_byte, first_of_frame,
				last_of_frame, time_seconds}));
			void'(pending_reqs.pop_front());
		end
		if (!(in_valid && in_stall)) begin
			if (gap > 0)
				gap <= gap - 1;
			if (hold || gap > 0 || pending_reqs.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				r = pending_reqs[0];
				in_valid <= 1'b1;
				arrival_port <= r.port;
				data_byte <= r.data;
				first_of_frame <= r.first;
				last_of_frame <= r.last;
				time_seconds <= r.secs;
				if (!quiet && $urandom_range(0, 9) == 0)
					gap <= $urandom_range(1, 14);
			end
		end
	end

	// Monitor.
	int ostall = 0;
	always @(posedge clk) begin
		res_t e;
		if (out_valid && !out_stall) begin
			n_results++;
			if (expected_res.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected result byte %h", out_byte);
			end else begin
				e = expected_res.pop_front();
				if (e.obyte !== out_byte || e.dport !== destination_port ||
				    e.fend !== frame_end || e.verd !== verdict || e.rec !== recorded) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp %h/%b/%b/%0d/%b got %h/%b/%b/%0d/%b",
							e.obyte, e.dport, e.fend, e.verd, e.rec,
							out_byte, destination_port, frame_end, verdict, recorded);
				end else begin
					if (e.verd == VERDICT_DROP)
						n_drops++;
					if (e.rec)
						n_recs++;
				end
			end
		end
		if (ostall > 0) begin
			ostall <= ostall - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 12) == 0) begin
			ostall <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	task automatic reg_write(input logic addr_sel, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(8 * int'(addr_sel));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr_sel == REG_OWN_MAC)
			mac_q = val[47:0];
		else
			expiry_q = val[7:0];
	endtask

	task automatic push_frame(input logic [7:0] body[], input logic port, input logic [31:0] secs,
		input bit mark_first);
		for (int k = 0; k < body.size(); k++)
			pending_reqs.push_back({port, body[k], (k == 0) && mark_first,
				k == body.size() - 1, secs});
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (2 * NENT + 40) @(posedge clk);
	endtask

	logic [7:0] frames[8][];
	logic [7:0] fr[];
	logic [31:0] now_s = 32'd100;
	int n_items = 0;

	task automatic random_frame(output logic [7:0] f[]);
		int unsigned len;
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 14);
		f = new[len];
		for (int k = 0; k < len; k++)
			f[k] = ($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(0, 3));
	endtask

	initial begin
		logic [7:0] echo[];
		logic p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		reg_write(REG_OWN_MAC, 64'h0000_A1B2_C3D4_E5F6);
		reg_write(REG_EXPIRY, 64'd2);
		// Directed: single byte, extremes, MAC rewrite, echo drop, missing and inner first marks.
		fr = new[1]; fr[0] = 8'hFF;
		push_frame(fr, 1'b1, 32'hFFFF_FFFF, 1);
		push_frame(fr, 1'b0, 32'hFFFF_FFFF, 1);
		fr = new[14];
		foreach (fr[k]) fr[k] = 8'(k * 17);
		push_frame(fr, 1'b0, 32'd0, 0);
		fr = new[3]; fr = '{8'h00, 8'h80, 8'h7F};
		pending_reqs.push_back({1'b1, 8'h55, 1'b1, 1'b0, 32'd5});
		push_frame(fr, 1'b1, 32'd5, 1);
		drain();
		echo = new[14];
		foreach (echo[k]) echo[k] = (k >= 6 && k < 12) ? mac_q[8*(11-k) +: 8] : 8'(k * 17);
		push_frame(echo, 1'b1, 32'd1, 1);
		fr = '{8'h00, 8'h80, 8'h7F};
		push_frame(fr, 1'b0, 32'd9, 1);
		drain();
		reg_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF);
		reg_write(REG_EXPIRY, 64'd255);
		fr = new[MAXF + 3];
		foreach (fr[k]) fr[k] = 8'($urandom);
		push_frame(fr, 1'b0, 32'd3, 1);
		drain();
		reg_write(REG_EXPIRY, 64'd0);
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 2) begin
				reg_write(REG_OWN_MAC, 64'd0);
				reg_write(REG_EXPIRY, 64'd3);
			end
			if (phase == 3) begin
				reg_write(REG_OWN_MAC, {16'd0, 32'($urandom), 16'($urandom)});
				reg_write(REG_EXPIRY, 64'd1);
				quiet = 1'b1;
			end
			for (int i = 0; i < 8; i++)
				random_frame(frames[i]);
			while (n_items < 140 * (phase + 1)) begin
				p = $urandom_range(0, 1);
				if ($urandom_range(0, 3) == 0)
					now_s += $urandom_range(0, 3);
				if ($urandom_range(0, 60) == 0)
					now_s -= 5;
				case ($urandom_range(0, 9)) inside
					0, 1: random_frame(fr);
					9: begin
						random_frame(fr);
						fr = new[fr.size() / 2 + 1](fr);
					end
					default: begin
						fr = frames[$urandom_range(0, 7)];
						// An echo arriving on port 1 carries our rewritten source.
						if (p)
							for (int k = 6; k < 12 && k < fr.size(); k++)
								fr[k] = mac_q[8*(11-k) +: 8];
					end
				endcase
				push_frame(fr, p, now_s, $urandom_range(0, 7) != 0);
				n_items += fr.size();
				if (n_items > 300 && n_items < 320) begin
					drain();
					n_items += 20;
				end
			end
			drain();
		end
		$display("%0d results checked, %0d echoes dropped, %0d frames recorded.",
			n_results, n_drops, n_recs);
		if (errors == 0)
			$display("bridge_echo_suppressor test passed");
		else
			$display("bridge_echo_suppressor test failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("bridge_echo_suppressor test failed");
		$finish;
	end
endmodule
`default_nettype wire

/* bridge_echo_suppressor.f */
rtl/bes_pkg.sv
rtl/bes_ram.sv
rtl/bes_ctrl.sv
rtl/bes_datapath.sv
rtl/bridge_echo_suppressor.sv
rtl/bes_checker.sv
bench/tb_top.sv
